// File: hdl/cdte_pkg.sv
// constants and month table for the calendar date to epoch seconds converter
`default_nettype none

package cdte_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned OUT_W    = 38;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned DAYS_W   = 23;
  localparam int unsigned TOD_W    = 17;
  localparam int unsigned MDAY_W   = 10;
  localparam int unsigned PROD_W   = 25;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 14'd1970;
  // leap years in 1..1969
  localparam logic [12:0]       LEAPS_BEFORE  = 13'd477;
  // x / 25 == (x * RECIP25) >> RECIP_SHIFT for x below 4096
  localparam logic [12:0]       RECIP25       = 13'd5243;
  localparam int unsigned       RECIP_SHIFT   = 17;
  localparam logic [16:0]       SECS_PER_DAY  = 17'd86400;
  localparam logic [OUT_W-1:0]  OUT_MAX       = {OUT_W{1'b1}};

  // days before the start of month wm+1 in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] wm);
    logic [8:0] d;
    case (wm)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hdl/calendar_date_to_epoch_seconds_core.sv
// calendar timestamp to seconds since 1970-01-01 00:00:00, five-stage pipeline
//
//   channel   direction  handshake          payload
//   input     in         start / busy       cal_year cal_month cal_day cal_hour
//                                           cal_minute cal_second
//   result    out        done (one cycle)   epoch_seconds
//
// one word is taken every cycle; busy stays low, the pipeline always flows
// stages: reciprocal multiplies, year and month day counts, day sum,
//   multiply by 86400, add time of day and saturate
// rst (synchronous) clears the valid bits only; words in flight are dropped
// the receiver cannot stall, so nothing is held back
`default_nettype none

module calendar_date_to_epoch_seconds_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cdte_pkg::YEAR_W-1:0]   cal_year,
  input  wire logic [3:0]                    cal_month,
  input  wire logic [4:0]                    cal_day,
  input  wire logic [4:0]                    cal_hour,
  input  wire logic [5:0]                    cal_minute,
  input  wire logic [5:0]                    cal_second,
  output logic                               done,
  output logic [cdte_pkg::OUT_W-1:0]         epoch_seconds
);

  localparam int unsigned YW = cdte_pkg::YEAR_W;
  localparam int unsigned PW = cdte_pkg::PROD_W;
  localparam int unsigned SH = cdte_pkg::RECIP_SHIFT;

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1 ----------------
  logic            v1;
  logic [YW-1:0]   yr1;
  logic            gt1;
  logic [11:0]     n4_1;
  logic [PW-1:0]   n4p1, n16p1, y4p1, y16p1;
  logic [8:0]      dbm1;
  logic            ge2_1;
  logic [4:0]      dadd1;
  logic [cdte_pkg::TOD_W-1:0] tod1;

  logic [YW-1:0]   n_next;
  logic [3:0]      wm_next;
  logic [11:0]     n4_next, y4_next;
  logic [9:0]      n16_next, y16_next;

  always_comb begin
    n_next   = cal_year - 14'd1;
    n4_next  = n_next[YW-1:2];
    n16_next = n_next[YW-1:4];
    y4_next  = cal_year[YW-1:2];
    y16_next = cal_year[YW-1:4];
    if (cal_month == 4'd0) begin
      wm_next = 4'd0;
    end else if (cal_month > 4'd13) begin
      wm_next = 4'd12;
    end else begin
      wm_next = cal_month - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    yr1   <= cal_year;
    gt1   <= cal_year > cdte_pkg::EPOCH_YEAR;
    n4_1  <= n4_next;
    n4p1  <= PW'(n4_next)  * PW'(cdte_pkg::RECIP25);
    n16p1 <= PW'(n16_next) * PW'(cdte_pkg::RECIP25);
    y4p1  <= PW'(y4_next)  * PW'(cdte_pkg::RECIP25);
    y16p1 <= PW'(y16_next) * PW'(cdte_pkg::RECIP25);
    dbm1  <= cdte_pkg::days_before_month(wm_next);
    ge2_1 <= wm_next >= 4'd2;
    dadd1 <= (cal_day > 5'd1) ? cal_day - 5'd1 : 5'd0;
    tod1  <= cdte_pkg::TOD_W'(cal_hour) * 17'd3600
           + cdte_pkg::TOD_W'(cal_minute) * 17'd60
           + cdte_pkg::TOD_W'(cal_second);
  end

  // ---------------- stage 2 ----------------
  logic            v2;
  logic            leap2;
  logic [cdte_pkg::DAYS_W-1:0] yday2;
  logic [cdte_pkg::MDAY_W-1:0] mday2;
  logic [cdte_pkg::TOD_W-1:0]  tod2;
  logic [1:0]      yr2_lo;

  logic [7:0]      q100, y4q;
  logic [5:0]      q400, y16q;
  logic [12:0]     lp_next;
  logic            leap_next;
  logic            div100, div400;
  logic [YW-1:0]   yoff_next;

  always_comb begin
    q100 = n4p1[SH+7:SH];
    q400 = n16p1[SH+5:SH];
    y4q  = y4p1[SH+7:SH];
    y16q = y16p1[SH+5:SH];
    // year divisible by 100: by 4 and year/4 divisible by 25
    div100 = (yr1[1:0] == 2'b00) && (12'(y4q) * 12'd25 == yr1[YW-1:2]);
    div400 = (yr1[3:0] == 4'b0000) && (10'(y16q) * 10'd25 == yr1[YW-1:4]);
    leap_next = ((yr1[1:0] == 2'b00) && !div100) || div400;
    lp_next   = 13'(n4_1) - 13'(q100) + 13'(q400) - cdte_pkg::LEAPS_BEFORE;
    yoff_next = yr1 - cdte_pkg::EPOCH_YEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    leap2  <= leap_next;
    yr2_lo <= yr1[1:0];
    yday2  <= gt1 ? cdte_pkg::DAYS_W'(yoff_next) * 23'd365 + cdte_pkg::DAYS_W'(lp_next)
                  : '0;
    mday2  <= cdte_pkg::MDAY_W'(dbm1) + cdte_pkg::MDAY_W'(dadd1)
            + cdte_pkg::MDAY_W'(ge2_1 && leap_next);
    tod2   <= tod1;
  end

  // ---------------- stage 3 ----------------
  logic            v3;
  logic [cdte_pkg::DAYS_W-1:0] days3;
  logic [cdte_pkg::TOD_W-1:0]  tod3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    days3 <= yday2 + cdte_pkg::DAYS_W'(mday2);
    tod3  <= tod2;
  end

  // ---------------- stage 4 ----------------
  logic            v4;
  logic [cdte_pkg::SUM_W-1:0] prod4;
  logic [cdte_pkg::TOD_W-1:0] tod4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    prod4 <= cdte_pkg::SUM_W'(days3) * cdte_pkg::SUM_W'(cdte_pkg::SECS_PER_DAY);
    tod4  <= tod3;
  end

  // ---------------- stage 5 ----------------
  logic [cdte_pkg::SUM_W-1:0] total_next;

  assign total_next = prod4 + cdte_pkg::SUM_W'(tod4);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    // saturate past 38 bits
    epoch_seconds <= (total_next[cdte_pkg::SUM_W-1:cdte_pkg::OUT_W] != '0)
                   ? cdte_pkg::OUT_MAX : total_next[cdte_pkg::OUT_W-1:0];
  end

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("accepted word did not come out after five cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result strobe without a matching input word");

  a_leap_mult4: assert property (@(posedge clk) disable iff (rst)
    (v2 && leap2) |-> (yr2_lo == 2'b00))
    else $error("leap year flagged for a year not divisible by four");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (prod4[cdte_pkg::SUM_W-1] == 1'b0))
    else $error("day product overflowed");

endmodule

`default_nettype wire

// File: verif/tb_calendar_date_to_epoch_seconds_core.sv
// testbench for the calendar timestamp to epoch seconds converter
`timescale 1ns / 100ps

module tb_calendar_date_to_epoch_seconds_core;

  localparam int unsigned      FIRST_YEAR  = 1970;
  localparam int unsigned      LATENCY     = 5;
  localparam int unsigned      MAX_GAP     = 17;
  localparam int unsigned      RANDOM_WORDS = 1850;
  localparam int unsigned      STALL_LIMIT = 400;
  localparam int unsigned      REPORT_MAX  = 10;
  localparam longint unsigned  SAT_VALUE   = (64'd1 << cdte_pkg::OUT_W) - 64'd1;
  localparam int unsigned      DIRECTED_ROWS = 23;
  // days before the first of month wm+1 in a common year
  localparam int unsigned      MONTH_START [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
  localparam int unsigned      EDGE_YEARS [10] =
    '{1900, 1968, 1969, 1972, 2000, 2100, 2400, 9996, 10680, 16383};

  typedef struct packed {
    logic [cdte_pkg::YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } stamp_t;

  typedef struct packed {
    stamp_t           stamp;
    logic             typed;
    logic [cdte_pkg::OUT_W-1:0] secs;
  } row_t;

  typedef struct packed {
    stamp_t           stamp;
    logic [cdte_pkg::OUT_W-1:0] secs;
  } due_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [cdte_pkg::YEAR_W-1:0] cal_year = '0;
  logic [3:0]          cal_month = '0;
  logic [4:0]          cal_day = '0;
  logic [4:0]          cal_hour = '0;
  logic [5:0]          cal_minute = '0;
  logic [5:0]          cal_second = '0;
  logic                done;
  logic [cdte_pkg::OUT_W-1:0] epoch_seconds;

  due_t        pending_epochs [$];
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned saturated_seen = 0;
  int unsigned pre_epoch_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  calendar_date_to_epoch_seconds_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cal_year      (cal_year),
    .cal_month     (cal_month),
    .cal_day       (cal_day),
    .cal_hour      (cal_hour),
    .cal_minute    (cal_minute),
    .cal_second    (cal_second),
    .done          (done),
    .epoch_seconds (epoch_seconds)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned leaps_upto(input longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic logic [cdte_pkg::OUT_W-1:0] seconds_since_epoch(input stamp_t s);
    longint unsigned days;
    longint unsigned total;
    longint unsigned yr;
    int unsigned     wm;
    logic            leap;
    yr = s.year;
    days = 0;
    if (yr > FIRST_YEAR) begin
      days = (yr - FIRST_YEAR) * 365 + leaps_upto(yr - 1) - leaps_upto(FIRST_YEAR - 1);
    end
    wm = (s.month == 0) ? 0 : s.month - 1;
    if (wm > 12) begin
      wm = 12;
    end
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    days += MONTH_START[wm];
    if (wm >= 2 && leap) begin
      days += 1;
    end
    if (s.day > 1) begin
      days += s.day - 1;
    end
    total = days * 86400 + longint'(s.hour) * 3600 + longint'(s.minute) * 60
          + longint'(s.second);
    if (total > SAT_VALUE) begin
      total = SAT_VALUE;
    end
    return total[cdte_pkg::OUT_W-1:0];
  endfunction

  function automatic row_t row(input int unsigned y, input int unsigned mo,
                               input int unsigned d, input int unsigned h,
                               input int unsigned mi, input int unsigned s,
                               input logic typed, input longint unsigned secs);
    row_t r;
    r.stamp.year   = y[cdte_pkg::YEAR_W-1:0];
    r.stamp.month  = mo[3:0];
    r.stamp.day    = d[4:0];
    r.stamp.hour   = h[4:0];
    r.stamp.minute = mi[5:0];
    r.stamp.second = s[5:0];
    r.typed        = typed;
    r.secs         = secs[cdte_pkg::OUT_W-1:0];
    return r;
  endfunction

  function automatic stamp_t random_stamp();
    stamp_t      s;
    logic [63:0] raw;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // any bit pattern, fields past their ranges included
      raw = {$urandom, $urandom};
      s = stamp_t'(raw[$bits(stamp_t)-1:0]);
    end else begin
      if (pick < 70) begin
        s.year = cdte_pkg::YEAR_W'($urandom_range(FIRST_YEAR, 9999));
      end else if (pick < 85) begin
        s.year = cdte_pkg::YEAR_W'($urandom_range(0, FIRST_YEAR - 1));
      end else begin
        s.year = cdte_pkg::YEAR_W'(EDGE_YEARS[$urandom_range(0, 9)]);
      end
      s.month  = 4'($urandom_range(1, 12));
      s.day    = 5'($urandom_range(1, 31));
      s.hour   = 5'($urandom_range(0, 23));
      s.minute = 6'($urandom_range(0, 59));
      s.second = 6'($urandom_range(0, 59));
    end
    return s;
  endfunction

  // result side: compare every done word with the oldest expectation
  always @(posedge clk) begin
    due_t want;
    if (!rst && done) begin
      if (pending_epochs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected result word: epoch_seconds=%0d", epoch_seconds);
        end
      end else begin
        want = pending_epochs.pop_front();
        words_checked++;
        if (epoch_seconds == SAT_VALUE[cdte_pkg::OUT_W-1:0]) begin
          saturated_seen++;
        end
        if (epoch_seconds !== want.secs) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch %0d-%0d-%0d %0d:%0d:%0d: expected %0d, got %0d",
                     want.stamp.year, want.stamp.month, want.stamp.day,
                     want.stamp.hour, want.stamp.minute, want.stamp.second,
                     want.secs, epoch_seconds);
          end
        end
      end
    end
  end

  // watchdog on cycles where no word moves on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t        directed [DIRECTED_ROWS];
    row_t        cur;
    int unsigned total_words;
    int unsigned gap;
    int unsigned burst_left;
    directed = '{
      row(1970, 1, 1, 0, 0, 0, 1'b1, 0),
      row(1970, 1, 1, 0, 0, 1, 1'b1, 1),
      row(1970, 1, 1, 1, 0, 0, 1'b1, 3600),
      row(1970, 1, 2, 0, 0, 0, 1'b1, 86400),
      row(1971, 1, 1, 0, 0, 0, 1'b1, 31536000),
      row(2000, 3, 1, 0, 0, 0, 1'b1, 951868800),
      row(2038, 1, 19, 3, 14, 7, 1'b1, 2147483647),
      row(9999, 12, 31, 23, 59, 59, 1'b1, 64'd253402300799),
      row(16383, 15, 31, 31, 63, 63, 1'b1, SAT_VALUE),
      row(0, 0, 0, 0, 0, 0, 1'b1, 0),
      row(1969, 12, 31, 23, 59, 59, 1'b0, 0),
      row(1968, 3, 1, 0, 0, 0, 1'b0, 0),
      row(2000, 2, 29, 12, 30, 30, 1'b0, 0),
      row(1900, 3, 1, 0, 0, 0, 1'b0, 0),
      row(2100, 3, 1, 0, 0, 0, 1'b0, 0),
      row(2400, 3, 1, 0, 0, 0, 1'b0, 0),
      row(2023, 13, 1, 0, 0, 0, 1'b0, 0),
      row(2024, 0, 15, 8, 0, 0, 1'b0, 0),
      row(2023, 2, 31, 0, 0, 0, 1'b0, 0),
      row(1999, 6, 15, 31, 63, 63, 1'b0, 0),
      row(10680, 6, 15, 12, 0, 0, 1'b0, 0),
      row(10681, 1, 1, 0, 0, 0, 1'b0, 0),
      row(0, 12, 31, 23, 59, 59, 1'b0, 0)
    };
    total_words = DIRECTED_ROWS + RANDOM_WORDS;
    burst_left = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int unsigned i = 0; i < total_words; i++) begin
      if (i < DIRECTED_ROWS) begin
        cur = directed[i];
      end else begin
        cur.stamp = random_stamp();
        cur.typed = 1'b0;
        cur.secs  = '0;
      end
      if (!cur.typed) begin
        cur.secs = seconds_since_epoch(cur.stamp);
      end

      // back-to-back stretches between randomly spaced words
      if (burst_left == 0 && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(10, 60);
      end
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end

      start      <= 1'b1;
      cal_year   <= cur.stamp.year;
      cal_month  <= cur.stamp.month;
      cal_day    <= cur.stamp.day;
      cal_hour   <= cur.stamp.hour;
      cal_minute <= cur.stamp.minute;
      cal_second <= cur.stamp.second;
      do @(posedge clk); while (busy);
      pending_epochs.push_back('{stamp: cur.stamp, secs: cur.secs});
      words_sent++;
      if (cur.stamp.year < FIRST_YEAR) begin
        pre_epoch_sent++;
      end
    end
    start <= 1'b0;

    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);

    $display("%0d timestamps sent (%0d before the epoch year), %0d results checked",
             words_sent, pre_epoch_sent, words_checked);
    $display("%0d saturated results, %0d mismatches", saturated_seen, mismatches);
    if (mismatches == 0 && pending_epochs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: calendar_date_to_epoch_seconds_core.f
hdl/cdte_pkg.sv
hdl/calendar_date_to_epoch_seconds_core.sv
verif/tb_calendar_date_to_epoch_seconds_core.sv
